// ===== src/decimal_fixed_point_parser_macros.svh =====
// assertion macros for the decimal fixed-point parser
// no dependencies
`ifndef DECIMAL_FIXED_POINT_PARSER_MACROS_SVH
`define DECIMAL_FIXED_POINT_PARSER_MACROS_SVH
// implication checked on every clock unless reset is low
`define DFP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define DFP_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== src/dfpp_pkg.sv =====
// shared types and constants of the decimal fixed-point parser
// no dependencies
package dfpp_pkg;
    localparam int COUNTER_BITS_DEF = 16;
    localparam int MAG_W = 60;
    localparam int AMT_W = 61;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [MAG_W-1:0] MAG_LIMIT = 60'd999999999999999999;
    localparam logic [MAG_W-1:0] MAG_TENTH = 60'd99999999999999999;
    localparam logic [4:0] DP_RESET = 5'd8;

    // character codes of the grammar
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    typedef enum logic [3:0] {
        PH_START, PH_SIGN, PH_INT, PH_ZERO, PH_POINT,
        PH_FRAC, PH_EXP_MARK, PH_EXP_SIGN, PH_EXP
    } t_phase;

    // classified action handed from front to back
    typedef enum logic [2:0] {
        OP_NONE, OP_MANT, OP_FRAC, OP_EXP, OP_FAIL
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE, BK_STEP, BK_MUL, BK_FIN, BK_CHECK, BK_SCALE, BK_OUT
    } t_bstate;

    typedef struct packed {
        t_op        op;
        logic [3:0] digit;
        logic       neg;
        logic       exp_neg;
        logic       last;
        logic       ok_end;
    } t_cmd;

    // largest magnitude that stays in range after k multiplies by ten
    function automatic logic [MAG_W-1:0] scale_limit(input logic [4:0] k);
        logic [MAG_W-1:0] v;
        case (k)
            5'd0:    v = 60'd999999999999999999;
            5'd1:    v = 60'd99999999999999999;
            5'd2:    v = 60'd9999999999999999;
            5'd3:    v = 60'd999999999999999;
            5'd4:    v = 60'd99999999999999;
            5'd5:    v = 60'd9999999999999;
            5'd6:    v = 60'd999999999999;
            5'd7:    v = 60'd99999999999;
            5'd8:    v = 60'd9999999999;
            5'd9:    v = 60'd999999999;
            5'd10:   v = 60'd99999999;
            5'd11:   v = 60'd9999999;
            5'd12:   v = 60'd999999;
            5'd13:   v = 60'd99999;
            5'd14:   v = 60'd9999;
            5'd15:   v = 60'd999;
            5'd16:   v = 60'd99;
            5'd17:   v = 60'd9;
            default: v = 60'd0;
        endcase
        return v;
    endfunction
endpackage

// ===== src/dfpp_if.sv =====
// valid/ready channel interfaces of the decimal fixed-point parser
// depends on dfpp_pkg
interface dfpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
    modport source (output valid, char_code, has_char, last, input ready);
    modport sink (input valid, char_code, has_char, last, output ready);
endinterface

interface dfpp_out_if import dfpp_pkg::*;;
    logic             valid;
    logic             ready;
    logic             valid_res;
    logic [AMT_W-1:0] amount;
    modport source (output valid, valid_res, amount, input ready);
    modport sink (input valid, valid_res, amount, output ready);
endinterface

// ===== src/dfpp_front.sv =====
// front: grammar tracking and classification of each character beat
// depends on dfpp_pkg
module dfpp_front import dfpp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic [7:0] i_char,
    input  logic   i_has,
    input  logic   i_last,
    output logic   o_push,
    output t_cmd   o_cmd,
    input  logic   i_full
);
    t_phase r_phase, n_phase;
    logic r_neg, n_neg, r_eneg, n_eneg, r_fail, n_fail;
    logic dig, bad;
    t_op  op;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign dig = i_char >= CH_ZERO && i_char <= CH_NINE;

    // grammar step
    always_comb begin
        n_phase = r_phase; n_neg = r_neg; n_eneg = r_eneg;
        bad = 1'b0; op = OP_NONE;
        unique case (r_phase)
            PH_START, PH_SIGN: begin
                if (r_phase == PH_START && i_char == CH_MINUS) begin
                    n_neg = 1'b1; n_phase = PH_SIGN;
                end else if (i_char == CH_ZERO) n_phase = PH_ZERO;
                else if (dig) begin n_phase = PH_INT; op = OP_MANT; end
                else bad = 1'b1;
            end
            PH_INT, PH_ZERO: begin
                if (r_phase == PH_INT && dig) op = OP_MANT;
                else if (i_char == CH_POINT) n_phase = PH_POINT;
                else if (i_char == CH_E_LO || i_char == CH_E_UP) n_phase = PH_EXP_MARK;
                else bad = 1'b1;
            end
            PH_POINT: begin
                if (dig) begin n_phase = PH_FRAC; op = OP_FRAC; end
                else bad = 1'b1;
            end
            PH_FRAC: begin
                if (dig) op = OP_FRAC;
                else if (i_char == CH_E_LO || i_char == CH_E_UP) n_phase = PH_EXP_MARK;
                else bad = 1'b1;
            end
            PH_EXP_MARK, PH_EXP_SIGN, PH_EXP: begin
                if (r_phase == PH_EXP_MARK && i_char == CH_PLUS) n_phase = PH_EXP_SIGN;
                else if (r_phase == PH_EXP_MARK && i_char == CH_MINUS) begin
                    n_eneg = 1'b1; n_phase = PH_EXP_SIGN;
                end else if (dig) begin n_phase = PH_EXP; op = OP_EXP; end
                else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (!i_has || r_fail) begin
            n_phase = r_phase; n_neg = r_neg; n_eneg = r_eneg; op = OP_NONE; bad = 1'b0;
        end
        n_fail = r_fail || bad;
        if (bad) op = OP_FAIL;
    end

    // command to the queue
    always_comb begin
        o_cmd.op      = op;
        o_cmd.digit   = i_char[3:0];
        o_cmd.neg     = n_neg;
        o_cmd.exp_neg = n_eneg;
        o_cmd.last    = i_last;
        o_cmd.ok_end  = !n_fail && (n_phase == PH_INT || n_phase == PH_ZERO ||
                        n_phase == PH_FRAC || n_phase == PH_EXP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_neg <= 1'b0; r_eneg <= 1'b0; r_fail <= 1'b0;
        end else if (o_push) begin
            if (i_last) begin
                r_phase <= PH_START; r_neg <= 1'b0; r_eneg <= 1'b0; r_fail <= 1'b0;
            end else begin
                r_phase <= n_phase; r_neg <= n_neg; r_eneg <= n_eneg; r_fail <= n_fail;
            end
        end
    end
endmodule

// ===== src/dfpp_queue.sv =====
// small command fifo between front and back
// depends on dfpp_pkg
module dfpp_queue import dfpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    t_cmd r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = r_cnt == (AW+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

// ===== src/dfpp_back.sv =====
// back: mantissa, counters and exponent arithmetic, final scaling
// depends on dfpp_pkg and the macros header
`include "decimal_fixed_point_parser_macros.svh"
module dfpp_back import dfpp_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [4:0] i_dp,
    input  logic i_empty,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic o_valid_res,
    output logic [AMT_W-1:0] o_amount
);
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;
    t_bstate r_st, n_st;
    logic [MAG_W-1:0] r_mag, r_emag;
    logic [COUNTER_BITS-1:0] r_tz, r_fd;
    logic r_fail;
    t_op r_op;
    logic [3:0] r_dig;
    logic r_last, r_okend, r_neg, r_eneg;
    logic [4:0] r_cnt;
    logic signed [63:0] r_scale;
    logic r_vres;
    logic [AMT_W-1:0] r_amt;
    logic [4:0] steps;
    logic is_mant, mant_bad, frac_bad, step_bad, need_mul, scale_bad;
    logic [MAG_W-1:0] mag_x10, emag_next;
    logic signed [63:0] sc;

    // number of multiplies by ten pending for a nonzero digit
    assign steps = (r_tz >= COUNTER_BITS'(18)) ? 5'd19 : 5'(r_tz + 1'b1);
    assign mag_x10 = {r_mag[MAG_W-4:0], 3'b000} + {r_mag[MAG_W-2:0], 1'b0};
    assign emag_next = {r_emag[MAG_W-4:0], 3'b000} + {r_emag[MAG_W-2:0], 1'b0}
                     + 60'(r_dig);

    // error checks of the current command
    assign is_mant  = r_op == OP_MANT || r_op == OP_FRAC;
    assign mant_bad = (r_dig == 4'd0) ? (r_tz == CMAX) : (r_mag > scale_limit(steps));
    assign frac_bad = (r_op == OP_FRAC) && (r_fd == CMAX);
    assign step_bad = (r_op == OP_FAIL) || (is_mant && (mant_bad || frac_bad)) ||
                      (r_op == OP_EXP && r_emag > MAG_TENTH);
    assign need_mul = is_mant && r_dig != 4'd0 && r_mag != '0 && !step_bad && !r_fail;

    // final scale and range test
    assign sc = (r_eneg ? -$signed({4'd0, r_emag}) : $signed({4'd0, r_emag}))
              - $signed(64'(r_fd)) + $signed(64'(r_tz)) + $signed(64'(i_dp));
    assign scale_bad = !r_okend || r_fail || r_scale < 0 || r_scale >= 64'sd18 ||
                       r_mag > scale_limit(r_scale[4:0]);

    assign o_valid_res = r_vres;
    assign o_amount = r_amt;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_IDLE:  if (!i_empty) n_st = BK_STEP;
            BK_STEP: begin
                if (need_mul) n_st = BK_MUL;
                else if (r_last) n_st = BK_FIN;
                else n_st = BK_IDLE;
            end
            BK_MUL:   if (r_cnt == 5'd0) n_st = r_last ? BK_FIN : BK_IDLE;
            BK_FIN:   n_st = BK_CHECK;
            BK_CHECK: n_st = scale_bad ? BK_OUT : BK_SCALE;
            BK_SCALE: if (r_cnt == 5'd0) n_st = BK_OUT;
            BK_OUT:   if (i_ready) n_st = BK_IDLE;
            default:  n_st = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop = 1'b0;
        o_valid = 1'b0;
        unique case (r_st)
            BK_IDLE: o_pop = !i_empty;
            BK_OUT:  o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BK_IDLE;
        else r_st <= n_st;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= '0; r_emag <= '0; r_tz <= '0; r_fd <= '0; r_fail <= 1'b0;
            r_op <= OP_NONE; r_dig <= '0; r_last <= 1'b0; r_okend <= 1'b0;
            r_neg <= 1'b0; r_eneg <= 1'b0; r_cnt <= '0; r_scale <= '0;
            r_vres <= 1'b0; r_amt <= '0;
        end else begin
            case (r_st)
                BK_IDLE: if (!i_empty) begin
                    r_op <= i_cmd.op; r_dig <= i_cmd.digit; r_last <= i_cmd.last;
                    r_okend <= i_cmd.ok_end; r_neg <= i_cmd.neg; r_eneg <= i_cmd.exp_neg;
                end
                BK_STEP: if (!r_fail) begin
                    if (step_bad) r_fail <= 1'b1;
                    else if (is_mant) begin
                        if (r_dig == 4'd0) r_tz <= r_tz + 1'b1;
                        else if (r_mag == '0) begin
                            r_mag <= 60'(r_dig); r_tz <= '0;
                        end else r_cnt <= steps;
                        if (r_op == OP_FRAC) r_fd <= r_fd + 1'b1;
                    end else if (r_op == OP_EXP) r_emag <= emag_next;
                end
                // repeated multiply by ten, then the digit
                BK_MUL: begin
                    if (r_cnt != 5'd0) begin
                        r_mag <= mag_x10; r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_mag <= r_mag + 60'(r_dig); r_tz <= '0;
                    end
                end
                BK_FIN: r_scale <= sc;
                BK_CHECK: begin
                    r_cnt <= r_scale[4:0]; r_vres <= 1'b0; r_amt <= '0;
                end
                BK_SCALE: begin
                    if (r_cnt != 5'd0) begin
                        r_mag <= mag_x10; r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_vres <= 1'b1;
                        r_amt <= r_neg ? -{1'b0, r_mag} : {1'b0, r_mag};
                    end
                end
                BK_OUT: if (i_ready) begin
                    r_mag <= '0; r_emag <= '0; r_tz <= '0; r_fd <= '0; r_fail <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    `DFP_ASSERT_IMP(a_inv_zero, i_clk, i_rst_n, o_valid && !o_valid_res, o_amount == '0)
    `DFP_ASSERT_IMP(a_no_pop_busy, i_clk, i_rst_n, r_st != BK_IDLE, !o_pop)
    `DFP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_amount))
endmodule

// ===== src/decimal_fixed_point_parser.sv =====
// Decimal fixed-point string parser. One character per input beat; the
// closing beat (last) yields one beat with valid_res and the scaled amount.
// Every beat costs the back end a take from the queue and an apply step. A
// nonzero mantissa digit after k held zeros on a nonzero mantissa adds k+1
// multiplies by ten, then the digit add. A closing beat adds the scale sum
// and range test, then the power-of-ten scaling, and then holds the result
// beat until it is taken. The 2-entry queue decouples the front, which
// stalls input only when the queue is full.
// depends on dfpp_pkg, dfpp_if, dfpp_front, dfpp_queue, dfpp_back
module decimal_fixed_point_parser import dfpp_pkg::*; #(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    dfpp_in_if.sink    s_in,
    dfpp_out_if.source m_out
);
    logic [4:0] r_dp;
    logic push, full, empty, pop;
    t_cmd cmd_in, cmd_out;

    // decimal places register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dp <= DP_RESET;
        else if (i_cfg_we) r_dp <= i_cfg_data;
    end

    dfpp_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_char(s_in.char_code), .i_has(s_in.has_char), .i_last(s_in.last),
        .o_push(push), .o_cmd(cmd_in), .i_full(full)
    );

    dfpp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(cmd_in), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_cmd(cmd_out)
    );

    dfpp_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
        .i_clk, .i_rst_n, .i_dp(r_dp), .i_empty(empty), .i_cmd(cmd_out), .o_pop(pop),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_valid_res(m_out.valid_res),
        .o_amount(m_out.amount)
    );
endmodule

// ===== tb/decimal_fixed_point_parser_tb.sv =====
// testbench for decimal_fixed_point_parser: character strings are sent as beats,
// results are checked against a behavioral predictor of the parser
// depends on dfpp_pkg, dfpp_if and the parser rtl
`timescale 1ns / 100ps

module decimal_fixed_point_parser_tb import dfpp_pkg::*;;

    localparam int CNT_BITS = COUNTER_BITS_DEF;
    localparam longint unsigned LIM = 64'd999999999999999999;
    localparam longint unsigned LIM_TENTH = 64'd99999999999999999;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic             valid_res;
        logic [AMT_W-1:0] amount;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [4:0] i_cfg_data;

    dfpp_in_if  in_ch();
    dfpp_out_if out_ch();

    decimal_fixed_point_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    // predictor state
    logic [4:0]      dp_cfg;
    t_phase          ph;
    longint unsigned mant;
    bit              neg;
    longint unsigned tzeros;
    longint unsigned fdigits;
    longint unsigned expo;
    bit              expo_neg;
    bit              parse_bad;

    t_result expected_results[$];
    int      errors;
    int      idle_pct;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_parse_state();
        ph = PH_START; mant = 0; neg = 0; tzeros = 0; fdigits = 0;
        expo = 0; expo_neg = 0; parse_bad = 0;
    endfunction

    function automatic bit add_mant_digit(logic [7:0] c);
        longint unsigned steps;
        if (c == "0") begin
            if (tzeros >= (64'd1 << CNT_BITS) - 1) return 0;
            tzeros++;
            return 1;
        end
        steps = tzeros + 1;
        if (steps > 19) steps = 19;
        for (longint unsigned i = 0; i < steps; i++) begin
            if (mant > LIM_TENTH) return 0;
            mant = mant * 10;
        end
        mant = mant + (c - "0");
        tzeros = 0;
        return 1;
    endfunction

    function automatic bit add_frac_digit(logic [7:0] c);
        if (!add_mant_digit(c)) return 0;
        if (fdigits >= (64'd1 << CNT_BITS) - 1) return 0;
        fdigits++;
        return 1;
    endfunction

    function automatic bit advance_grammar(logic [7:0] c);
        bit ok;
        ok = 0;
        case (ph)
            PH_START, PH_SIGN: begin
                if (ph == PH_START && c == "-") begin
                    neg = 1; ph = PH_SIGN; ok = 1;
                end else if (c == "0") begin
                    ph = PH_ZERO; ok = 1;
                end else if (is_dig(c)) begin
                    ph = PH_INT; ok = add_mant_digit(c);
                end
            end
            PH_INT, PH_ZERO: begin
                if (ph == PH_INT && is_dig(c)) ok = add_mant_digit(c);
                else if (c == ".") begin
                    ph = PH_POINT; ok = 1;
                end else if (c == "e" || c == "E") begin
                    ph = PH_EXP_MARK; ok = 1;
                end
            end
            PH_POINT, PH_FRAC: begin
                if (is_dig(c)) begin
                    ph = PH_FRAC; ok = add_frac_digit(c);
                end else if (ph == PH_FRAC && (c == "e" || c == "E")) begin
                    ph = PH_EXP_MARK; ok = 1;
                end
            end
            PH_EXP_MARK, PH_EXP_SIGN, PH_EXP: begin
                if (ph == PH_EXP_MARK && c == "+") begin
                    ph = PH_EXP_SIGN; ok = 1;
                end else if (ph == PH_EXP_MARK && c == "-") begin
                    expo_neg = 1; ph = PH_EXP_SIGN; ok = 1;
                end else if (is_dig(c)) begin
                    ph = PH_EXP;
                    if (expo <= LIM_TENTH) begin
                        expo = expo * 10 + (c - "0"); ok = 1;
                    end
                end
            end
            default: ok = 0;
        endcase
        return ok;
    endfunction

    // scale the closing mantissa; returns validity
    function automatic bit scale_amount(output longint unsigned mag);
        longint sc;
        longint unsigned m;
        mag = 0;
        m = mant;
        if (!(ph inside {PH_INT, PH_ZERO, PH_FRAC, PH_EXP})) return 0;
        if (expo > 64'd4000000000000000000) return 0;
        sc = expo_neg ? -longint'(expo) : longint'(expo);
        sc = sc - longint'(fdigits) + longint'(tzeros) + longint'(dp_cfg);
        if (sc < 0 || sc >= 18) return 0;
        for (longint i = 0; i < sc; i++) begin
            if (m > LIM_TENTH) return 0;
            m = m * 10;
        end
        if (m > LIM) return 0;
        mag = m;
        return 1;
    endfunction

    function automatic void predict_char(logic [7:0] c, bit has, bit lst);
        t_result r;
        longint unsigned mag;
        bit ok;
        if (has && !parse_bad)
            if (!advance_grammar(c)) parse_bad = 1;
        if (!lst) return;
        ok = !parse_bad && scale_amount(mag);
        r.valid_res = ok;
        r.amount = ok ? (neg ? AMT_W'(-mag) : AMT_W'(mag)) : '0;
        expected_results.push_back(r);
        clear_parse_state();
    endfunction

    // send one beat, with random idle in front
    task automatic send_char(logic [7:0] c, bit has, bit lst);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.char_code <= c;
        in_ch.has_char <= has;
        in_ch.last <= lst;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_char(c, has, lst);
    endtask

    task automatic send_string(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, i == s.len() - 1);
        if (s.len() == 0) send_char(8'h00, 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_places(logic [4:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dp_cfg = v;
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat valid_res=%0b amount=%0h", $realtime,
                             out_ch.valid_res, out_ch.amount);
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (e.valid_res !== out_ch.valid_res || e.amount !== out_ch.amount) begin
                        errors++;
                        $display("%0t mismatch expected %0b/%0h actual %0b/%0h", $realtime,
                                 e.valid_res, e.amount, out_ch.valid_res, out_ch.amount);
                    end
                end
            end
        end
    end

    // watchdog over cycles with no accepted beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("decimal_fixed_point_parser test failed");
            $finish;
        end
    end

    task automatic test_directed();
        string cases[$];
        cases = '{"0", "-0", "1", "-999999999", "9999999999", "0.5", "-1.25e3",
                  "12E-4", "1e+2", "100", "1000e-3", "00", "-", "1.", "1e", "1e+",
                  "01", ".5", "1x", "9999999999999999999", "1e99999999999999999999",
                  "1.00000000e-8", "-12.3400"};
        foreach (cases[i]) send_string(cases[i]);
        send_string("");
        send_char("5", 1'b0, 1'b0);
        send_char("7", 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char("1", 1'b1, 1'b1);
    endtask

    task automatic test_places();
        logic [4:0] vals[6];
        vals = '{5'd0, 5'd17, 5'd31, 5'd18, 5'd3, 5'd8};
        foreach (vals[i]) begin
            write_places(vals[i]);
            send_string("1");
            send_string("-7.5e-3");
            send_string("12e-19");
            send_string("0.00000000000000001");
        end
    endtask

    task automatic send_digits(int n, bit lead_ok);
        for (int i = 0; i < n; i++)
            send_char(8'((i == 0 && lead_ok) ? "1" + $urandom_range(8)
                                             : "0" + $urandom_range(9)), 1'b1, 1'b0);
    endtask

    // one mostly well-formed string with random content
    task automatic send_random_number();
        int kind;
        kind = int'($urandom_range(99));
        if (kind < 12) begin
            int n;
            n = int'($urandom_range(1, 6));
            for (int i = 0; i < n; i++)
                send_char(8'($urandom_range(255)), 1'($urandom_range(1)), i == n - 1);
            return;
        end
        if ($urandom_range(1)) send_char("-", 1'b1, 1'b0);
        if ($urandom_range(4) == 0) send_char("0", 1'b1, 1'b0);
        else send_digits(int'($urandom_range(1, 8)), 1'b1);
        if ($urandom_range(1)) begin
            send_char(".", 1'b1, 1'b0);
            send_digits(int'($urandom_range(kind < 20 ? 0 : 1, 6)), 1'b0);
        end
        if ($urandom_range(2) == 0) begin
            send_char($urandom_range(1) ? "e" : "E", 1'b1, 1'b0);
            case ($urandom_range(2))
                0: send_char("+", 1'b1, 1'b0);
                1: send_char("-", 1'b1, 1'b0);
                default: ;
            endcase
            send_digits(int'($urandom_range(kind < 16 ? 0 : 1, 2)), 1'b0);
        end
        if (kind < 25) send_char(8'($urandom_range(255)), 1'b1, 1'b1);
        else send_char(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random();
        for (int n = 0; n < 72; n++) begin
            if (n == 20) idle_pct = 0;
            if (n == 40) idle_pct = 14;
            if (n == 50) drain_results();
            if (n == 60) write_places(5'($urandom_range(17)));
            send_random_number();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        in_ch.has_char = 1'b0;
        in_ch.last = 1'b0;
        idle_pct = 14;
        dp_cfg = DP_RESET;
        clear_parse_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_places();
        test_random();
        drain_results();
        if (errors == 0)
            $display("decimal_fixed_point_parser test passed");
        else
            $display("decimal_fixed_point_parser test failed");
        $finish;
    end
endmodule
